// ===== design/fmsyn_pkg.sv =====
// Package: constants, types and constant tables of the two-operator FM synthesizer.
`default_nettype none

package fmsyn_pkg;

  localparam int NumChannels   = 6;
  localparam int SineIndexBits = 10;
  localparam int PhaseWidth    = 18;
  localparam int MaxChannels   = 6;

  localparam logic [1:0] CmdLatch = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;

  localparam logic [3:0] GrpFnumLo = 4'd1;
  localparam logic [3:0] GrpFnumHi = 4'd2;
  localparam logic [3:0] GrpInstr  = 4'd3;

  localparam logic [1:0] StDamp    = 2'd0;
  localparam logic [1:0] StAttack  = 2'd1;
  localparam logic [1:0] StDecay   = 2'd2;
  localparam logic [1:0] StRelease = 2'd3;

  localparam logic [6:0] LevelMax   = 7'h7F;
  localparam logic [6:0] SustainMax = 7'd124;
  localparam logic [7:0] SampleMid  = 8'h80;
  localparam int         MixWidth   = 16;

  localparam logic [23:0] TremStep = 24'd87;
  localparam logic [19:0] VibStep  = 20'd152;

  localparam longint unsigned Q30One   = 64'd1 << 30;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Ln2Q30    = 64'd744261118;

  localparam longint unsigned SineDiv [12] = '{1, 6, 20, 42, 72, 110, 156, 210, 272, 342,
                                               420, 506};
  localparam longint unsigned ExpDiv [15] = '{1, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13,
                                              14};

  localparam logic [4:0] MultX2 [16] = '{5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
                                         5'd16, 5'd18, 5'd20, 5'd20, 5'd24, 5'd24, 5'd30,
                                         5'd30};

  localparam logic [7:0] PatchRom [15][8] = '{
    '{8'h03, 8'h21, 8'h05, 8'h06, 8'hE8, 8'h81, 8'h42, 8'h27},
    '{8'h13, 8'h41, 8'h14, 8'h0D, 8'hD8, 8'hF6, 8'h23, 8'h12},
    '{8'h11, 8'h11, 8'h08, 8'h08, 8'hFA, 8'hB2, 8'h20, 8'h12},
    '{8'h31, 8'h61, 8'h0C, 8'h07, 8'hA8, 8'h64, 8'h61, 8'h27},
    '{8'h32, 8'h21, 8'h1E, 8'h06, 8'hE1, 8'h76, 8'h01, 8'h28},
    '{8'h02, 8'h01, 8'h06, 8'h00, 8'hA3, 8'hE2, 8'hF4, 8'hF4},
    '{8'h21, 8'h61, 8'h1D, 8'h07, 8'h82, 8'h81, 8'h11, 8'h07},
    '{8'h23, 8'h21, 8'h22, 8'h17, 8'hA2, 8'h72, 8'h01, 8'h17},
    '{8'h35, 8'h11, 8'h25, 8'h00, 8'h40, 8'h73, 8'h72, 8'h01},
    '{8'hB5, 8'h01, 8'h0F, 8'h0F, 8'hA8, 8'hA5, 8'h51, 8'h02},
    '{8'h17, 8'hC1, 8'h24, 8'h07, 8'hF8, 8'hF8, 8'h22, 8'h12},
    '{8'h71, 8'h23, 8'h11, 8'h06, 8'h65, 8'h74, 8'h18, 8'h16},
    '{8'h01, 8'h02, 8'hD3, 8'h05, 8'hC9, 8'h95, 8'h03, 8'h02},
    '{8'h61, 8'h63, 8'h0C, 8'h00, 8'h94, 8'hC0, 8'h33, 8'hF6},
    '{8'h21, 8'h72, 8'h0D, 8'h00, 8'hC1, 8'hD5, 8'h56, 8'h06}
  };

  typedef enum logic [3:0] {
    S_IDLE, S_PAR, S_ENV1, S_ENV2, S_ARG, S_LOG, S_EXP, S_OUT, S_DONE
  } seq_state_t;

  typedef struct packed {
    logic       am;
    logic       vib;
    logic       egt;
    logic       ksr;
    logic [3:0] mult;
    logic [5:0] tl;
    logic [2:0] fb;
    logic [3:0] ar;
    logic [3:0] dr;
    logic [3:0] sl;
    logic [3:0] rr;
  } op_par_t;

  // -log2(sin) in 1/256 steps, quarter wave
  function automatic logic [15:0] sine_entry(int unsigned i, int unsigned bits);
    longint unsigned x, x2, t, m;
    longint s;
    int unsigned k, f, q, v;
    x = ((2 * longint'(i) + 1) * HalfPiQ30) >> (bits + 1);
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    k = 0;
    f = 0;
    for (int n = 1; n < 12; n++) begin
      t = ((t * x2) >> 30) / SineDiv[n];
      if (n % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s > longint'(Q30One)) s = longint'(Q30One);
    if (s < 1) s = 1;
    m = longint'(s);
    while (m < Q30One) begin
      m = m << 1;
      k = k + 1;
    end
    for (int n = 0; n < 16; n++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= 2 * Q30One) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    q = (k << 16) - f;
    v = (q + 128) >> 8;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // (2^(i/256) - 1) * 1024
  function automatic logic [9:0] exp_entry(int unsigned i);
    longint unsigned a, t, s;
    a = (longint'(i) * Ln2Q30) >> 8;
    t = Q30One;
    s = Q30One;
    for (int n = 1; n < 15; n++) begin
      t = ((t * a) >> 30) / ExpDiv[n];
      s = s + t;
    end
    return 10'(((s - Q30One) + (64'd1 << 19)) >> 20);
  endfunction

  function automatic logic [17:0] base_entry(int unsigned fnum);
    longint unsigned b;
    b = (longint'(fnum) * 49716 * 256 + 22050) / 44100;
    return 18'(b);
  endfunction

  function automatic logic [25:0] rate_step(int unsigned er, int unsigned att);
    longint unsigned s;
    if (er == 0) return '0;
    s = longint'(4 + (er % 4)) << (er / 4);
    s = s << 6;
    if (att != 0) s = s << 2;
    s = s * 49716 / 44100;
    return 26'(s);
  endfunction

endpackage

`default_nettype wire

// ===== design/fmsyn_ifs.sv =====
// Valid/ready channel interfaces for the synthesizer command and sample beats.
`default_nettype none

interface fmsyn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] value;
  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

interface fmsyn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

`default_nettype wire

// ===== design/fm_synth_two_operator_six_channel.sv =====
// Top level: six-channel two-operator FM synthesizer with a shared operator sequencer.
// Address latch and data write beats act in S_IDLE; input is ready only when idle.
// An enabled tick steps each operator through S_PAR, S_ENV1, S_ENV2, S_ARG, S_LOG, S_EXP
// and S_OUT, set by the single operator datapath with its registered sine and exp ROM reads.
// A disabled tick goes to S_DONE and returns 128. One sample register decouples the output.
// Synchronous reset restores all register-file defaults and leaves the block disabled.
`default_nettype none

module fm_synth_two_operator_six_channel #(
  parameter int NUM_CHANNELS    = fmsyn_pkg::NumChannels,
  parameter int SINE_INDEX_BITS = fmsyn_pkg::SineIndexBits,
  parameter int PHASE_WIDTH     = fmsyn_pkg::PhaseWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  fmsyn_in_if.sink    items,
  fmsyn_out_if.source samples
);

  localparam int ChW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SineSize = 1 << SINE_INDEX_BITS;
  localparam int PW       = PHASE_WIDTH;
  localparam logic [ChW-1:0] LastCh = ChW'(NUM_CHANNELS - 1);

  // constant tables
  logic [15:0] sine_tab [SineSize];
  logic [9:0]  exp_tab  [256];
  logic [17:0] base_tab [512];
  logic [25:0] rate_tab [128];

  for (genvar gi = 0; gi < SineSize; gi++) begin : g_sine
    localparam logic [15:0] Val = fmsyn_pkg::sine_entry(gi, SINE_INDEX_BITS);
    assign sine_tab[gi] = Val;
  end
  for (genvar gi = 0; gi < 256; gi++) begin : g_exp
    localparam logic [9:0] Val = fmsyn_pkg::exp_entry(gi);
    assign exp_tab[gi] = Val;
  end
  for (genvar gi = 0; gi < 512; gi++) begin : g_base
    localparam logic [17:0] Val = fmsyn_pkg::base_entry(gi);
    assign base_tab[gi] = Val;
  end
  for (genvar gi = 0; gi < 128; gi++) begin : g_rate
    localparam logic [25:0] Val = fmsyn_pkg::rate_step(gi % 64, gi / 64);
    assign rate_tab[gi] = Val;
  end

  // register file
  logic        enable;
  logic [7:0]  address_latch;
  logic [7:0]  user_patch      [8];
  logic [8:0]  chan_fnum       [NUM_CHANNELS];
  logic [2:0]  chan_octave     [NUM_CHANNELS];
  logic [3:0]  chan_instrument [NUM_CHANNELS];
  logic [3:0]  chan_volume     [NUM_CHANNELS];
  logic        chan_key        [NUM_CHANNELS];
  logic        chan_sustain    [NUM_CHANNELS];
  logic [PW-1:0] op_phase      [NUM_CHANNELS][2];
  logic [6:0]  op_env_level    [NUM_CHANNELS][2];
  logic [23:0] op_env_fraction [NUM_CHANNELS][2];
  logic [1:0]  op_env_stage    [NUM_CHANNELS][2];
  logic [11:0] hist_mod        [NUM_CHANNELS];
  logic [11:0] hist_car        [NUM_CHANNELS];
  logic [23:0] tremolo_phase;
  logic [19:0] vibrato_phase;

  // sequencer and datapath registers
  fmsyn_pkg::seq_state_t state, state_next;
  logic [ChW-1:0] ch;
  logic           op_car;
  fmsyn_pkg::op_par_t qr;
  logic [26:0] frs;
  logic [18:0] inc;
  logic [1:0]  quad;
  logic [15:0] lg;
  logic [15:0] sine_q;
  logic [9:0]  exp_q;
  logic [17:0] base_q;
  logic signed [11:0] mo;
  logic signed [fmsyn_pkg::MixWidth-1:0] mix;

  // operator parameters for the current channel and operator
  logic [3:0] ins;
  logic [7:0] pb [8];
  logic [7:0] pbyte, abyte, sbyte;
  fmsyn_pkg::op_par_t par;

  assign ins = chan_instrument[ch];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pb[k] = (ins == 4'd0) ? user_patch[k] : fmsyn_pkg::PatchRom[ins - 4'd1][k];
    end
    pbyte    = op_car ? pb[1] : pb[0];
    abyte    = op_car ? pb[5] : pb[4];
    sbyte    = op_car ? pb[7] : pb[6];
    par.am   = pbyte[7];
    par.vib  = pbyte[6];
    par.egt  = pbyte[5];
    par.ksr  = pbyte[4];
    par.mult = pbyte[3:0];
    par.tl   = op_car ? {2'b00, chan_volume[ch]} : pb[2][5:0];
    par.fb   = op_car ? 3'd0 : pb[3][2:0];
    par.ar   = abyte[7:4];
    par.dr   = abyte[3:0];
    par.sl   = sbyte[7:4];
    par.rr   = sbyte[3:0];
  end

  // envelope step
  logic [6:0]  lv;
  logic [1:0]  st;
  logic [23:0] fr;
  logic [3:0]  rsel;
  logic [3:0]  kv;
  logic [6:0]  er_full;
  logic [5:0]  er;
  logic [26:0] frs_next;
  logic [24:0] bsh;
  logic [29:0] prod;

  assign lv = op_env_level[ch][op_car];
  assign st = op_env_stage[ch][op_car];
  assign fr = op_env_fraction[ch][op_car];
  assign kv = {chan_octave[ch], chan_fnum[ch][8]};

  always_comb begin
    case (st)
      fmsyn_pkg::StAttack: rsel = qr.ar;
      fmsyn_pkg::StDecay:  rsel = qr.dr;
      default: begin
        if (chan_key[ch]) rsel = qr.egt ? 4'd0 : qr.rr;
        else rsel = chan_sustain[ch] ? 4'd5 : qr.rr;
      end
    endcase
    er_full  = {1'b0, rsel, 2'b00} + (qr.ksr ? {3'b000, kv} : {5'b00000, kv[3:2]});
    er       = (rsel == 4'd0) ? 6'd0 : ((er_full > 7'd63) ? 6'd63 : er_full[5:0]);
    frs_next = {3'b000, fr} + {1'b0, rate_tab[{st == fmsyn_pkg::StAttack, er}]};
    bsh      = {7'b0, base_q} << chan_octave[ch];
    prod     = bsh * fmsyn_pkg::MultX2[qr.mult];
  end

  logic [2:0]  adv;
  logic [10:0] prod_a;
  logic [7:0]  dec;
  logic [7:0]  sumd;
  logic [6:0]  tgt;
  logic [6:0]  lv_next;
  logic [1:0]  st_next;
  logic [23:0] fr_next;

  always_comb begin
    adv     = frs[26:24];
    prod_a  = ({3'b000, lv} + 11'd1) * {8'd0, adv};
    dec     = prod_a[10:3] + 8'd1;
    sumd    = {1'b0, lv} + {5'd0, adv};
    tgt     = (qr.sl < 4'd15) ? {1'b0, qr.sl, 2'b00} : fmsyn_pkg::SustainMax;
    lv_next = lv;
    st_next = st;
    fr_next = frs[23:0];
    case (st)
      fmsyn_pkg::StDamp: begin
        fr_next = fr;
        if (lv >= 7'd125) begin
          lv_next = fmsyn_pkg::LevelMax;
          st_next = fmsyn_pkg::StAttack;
          fr_next = '0;
        end else begin
          lv_next = lv + 7'd2;
        end
      end
      fmsyn_pkg::StAttack: begin
        if (adv != 3'd0) begin
          if (dec >= {1'b0, lv}) begin
            lv_next = '0;
            st_next = fmsyn_pkg::StDecay;
            fr_next = '0;
          end else begin
            lv_next = lv - dec[6:0];
          end
        end
      end
      fmsyn_pkg::StDecay: begin
        if (sumd >= {1'b0, tgt}) begin
          lv_next = tgt;
          st_next = fmsyn_pkg::StRelease;
          fr_next = '0;
        end else begin
          lv_next = sumd[6:0];
        end
      end
      default: lv_next = (sumd > 8'd127) ? fmsyn_pkg::LevelMax : sumd[6:0];
    endcase
  end

  // phase argument and sine address
  logic signed [11:0] h0, h1;
  logic signed [12:0] hsum, fbs;
  logic [5:0]  pv;
  logic [7:0]  t8, t8f;
  logic [3:0]  am_lvl;
  logic [PW-1:0] vterm, mterm, arg;
  logic [SINE_INDEX_BITS-1:0] sidx;

  always_comb begin
    h0     = hist_mod[ch];
    h1     = hist_car[ch];
    hsum   = {h0[11], h0} + {h1[11], h1};
    fbs    = (qr.fb != 3'd0) ? (hsum >>> (4'd8 - {1'b0, qr.fb})) : 13'sd0;
    pv     = vibrato_phase[19:14];
    t8     = tremolo_phase[23:16];
    t8f    = t8[7] ? ~t8 : t8;
    am_lvl = t8f[6:3];
    vterm  = qr.vib ? {{(PW - 6){pv[5]}}, pv} : '0;
    mterm  = op_car ? ({{(PW - 12){mo[11]}}, mo} << 8) : ({{(PW - 13){fbs[12]}}, fbs} << 8);
    arg    = op_phase[ch][op_car] + vterm + mterm;
    sidx   = arg[PW-3 -: SINE_INDEX_BITS] ^ {SINE_INDEX_BITS{arg[PW-2]}};
  end

  // log to linear
  logic [15:0] lg_next;
  logic [10:0] expv, lin;
  logic signed [11:0] val;

  always_comb begin
    lg_next = sine_q + {4'd0, lv, 5'd0} + {5'd0, qr.tl, 5'd0}
            + (qr.am ? {9'd0, am_lvl, 3'd0} : 16'd0);
    expv    = {1'b1, exp_q};
    lin     = (lg[15:8] > 8'd11) ? 11'd0 : (expv >> lg[11:8]);
    val     = quad[1] ? -$signed({1'b0, lin}) : $signed({1'b0, lin});
  end

  // output sample
  logic signed [fmsyn_pkg::MixWidth-1:0] sv;
  logic [7:0] smp;

  always_comb begin
    sv = (mix >>> 7) + fmsyn_pkg::MixWidth'(128);
    if (sv < 0) smp = 8'd0;
    else if (sv > fmsyn_pkg::MixWidth'(255)) smp = 8'hFF;
    else smp = sv[7:0];
  end

  // data write decode
  logic [3:0]     grp, wc;
  logic [ChW-1:0] wch;
  logic           wvalid;
  logic           key_in;

  always_comb begin
    grp    = address_latch[7:4];
    wc     = address_latch[3:0];
    wch    = wc[ChW-1:0];
    wvalid = (grp == fmsyn_pkg::GrpFnumLo || grp == fmsyn_pkg::GrpFnumHi
              || grp == fmsyn_pkg::GrpInstr) && ({28'd0, wc} < NUM_CHANNELS);
    key_in = items.value[4];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= fmsyn_pkg::S_IDLE;
    else state <= state_next;
  end

  assign items.ready = (state == fmsyn_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      fmsyn_pkg::S_IDLE: begin
        if (items.valid && items.command == fmsyn_pkg::CmdTick) begin
          state_next = enable ? fmsyn_pkg::S_PAR : fmsyn_pkg::S_DONE;
        end
      end
      fmsyn_pkg::S_PAR:  state_next = fmsyn_pkg::S_ENV1;
      fmsyn_pkg::S_ENV1: state_next = fmsyn_pkg::S_ENV2;
      fmsyn_pkg::S_ENV2: state_next = fmsyn_pkg::S_ARG;
      fmsyn_pkg::S_ARG:  state_next = fmsyn_pkg::S_LOG;
      fmsyn_pkg::S_LOG:  state_next = fmsyn_pkg::S_EXP;
      fmsyn_pkg::S_EXP:  state_next = fmsyn_pkg::S_OUT;
      fmsyn_pkg::S_OUT: begin
        state_next = (op_car && ch == LastCh) ? fmsyn_pkg::S_DONE : fmsyn_pkg::S_PAR;
      end
      fmsyn_pkg::S_DONE: begin
        if (!samples.valid || samples.ready) state_next = fmsyn_pkg::S_IDLE;
      end
      default: state_next = fmsyn_pkg::S_IDLE;
    endcase
  end

  // ROM reads
  always_ff @(posedge clk) begin
    base_q <= base_tab[chan_fnum[ch]];
    if (state == fmsyn_pkg::S_ARG) sine_q <= sine_tab[sidx];
    if (state == fmsyn_pkg::S_EXP) exp_q <= exp_tab[~lg[7:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      address_latch <= '0;
      tremolo_phase <= '0;
      vibrato_phase <= '0;
      samples.valid <= 1'b0;
      ch            <= '0;
      op_car        <= 1'b0;
      for (int k = 0; k < 8; k++) user_patch[k] <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_fnum[c]       <= '0;
        chan_octave[c]     <= '0;
        chan_instrument[c] <= '0;
        chan_volume[c]     <= 4'd15;
        chan_key[c]        <= 1'b0;
        chan_sustain[c]    <= 1'b0;
        hist_mod[c]        <= '0;
        hist_car[c]        <= '0;
        for (int j = 0; j < 2; j++) begin
          op_phase[c][j]        <= '0;
          op_env_level[c][j]    <= fmsyn_pkg::LevelMax;
          op_env_fraction[c][j] <= '0;
          op_env_stage[c][j]    <= fmsyn_pkg::StRelease;
        end
      end
    end else begin
      if (cfg_write) enable <= cfg_data;
      if (samples.valid && samples.ready) samples.valid <= 1'b0;
      unique case (state)
        fmsyn_pkg::S_IDLE: begin
          if (items.valid) begin
            case (items.command)
              fmsyn_pkg::CmdLatch: address_latch <= items.value;
              fmsyn_pkg::CmdWrite: begin
                if (address_latch < 8'd8) begin
                  user_patch[address_latch[2:0]] <= items.value;
                end else if (wvalid) begin
                  unique case (grp)
                    fmsyn_pkg::GrpFnumLo: chan_fnum[wch][7:0] <= items.value;
                    fmsyn_pkg::GrpFnumHi: begin
                      chan_fnum[wch][8] <= items.value[0];
                      chan_octave[wch]  <= items.value[3:1];
                      chan_key[wch]     <= key_in;
                      chan_sustain[wch] <= items.value[5];
                      if (key_in && !chan_key[wch]) begin
                        hist_mod[wch] <= '0;
                        hist_car[wch] <= '0;
                        for (int j = 0; j < 2; j++) begin
                          op_env_stage[wch][j]    <= fmsyn_pkg::StDamp;
                          op_env_fraction[wch][j] <= '0;
                        end
                      end else if (!key_in && chan_key[wch]) begin
                        for (int j = 0; j < 2; j++) begin
                          op_env_stage[wch][j] <= fmsyn_pkg::StRelease;
                        end
                      end
                    end
                    fmsyn_pkg::GrpInstr: begin
                      chan_instrument[wch] <= items.value[7:4];
                      chan_volume[wch]     <= items.value[3:0];
                    end
                    default: ;
                  endcase
                end
              end
              fmsyn_pkg::CmdTick: begin
                mix    <= '0;
                ch     <= '0;
                op_car <= 1'b0;
                if (enable) begin
                  tremolo_phase <= tremolo_phase + fmsyn_pkg::TremStep;
                  vibrato_phase <= vibrato_phase + fmsyn_pkg::VibStep;
                end
              end
              default: ;
            endcase
          end
        end
        fmsyn_pkg::S_PAR: qr <= par;
        fmsyn_pkg::S_ENV1: begin
          frs <= frs_next;
          inc <= prod[29:11];
        end
        fmsyn_pkg::S_ENV2: begin
          op_env_level[ch][op_car]    <= lv_next;
          op_env_stage[ch][op_car]    <= st_next;
          op_env_fraction[ch][op_car] <= fr_next;
          op_phase[ch][op_car]        <= op_phase[ch][op_car] + PW'(inc);
        end
        fmsyn_pkg::S_ARG: quad <= arg[PW-1:PW-2];
        fmsyn_pkg::S_LOG: lg <= lg_next;
        fmsyn_pkg::S_EXP: ;
        fmsyn_pkg::S_OUT: begin
          if (!op_car) begin
            mo           <= val;
            hist_car[ch] <= hist_mod[ch];
            hist_mod[ch] <= val;
            op_car       <= 1'b1;
          end else begin
            if (lv < fmsyn_pkg::LevelMax) begin
              mix <= mix + fmsyn_pkg::MixWidth'(val);
            end
            op_car <= 1'b0;
            if (ch != LastCh) ch <= ch + ChW'(1);
          end
        end
        fmsyn_pkg::S_DONE: begin
          if (!samples.valid || samples.ready) begin
            samples.valid  <= 1'b1;
            samples.sample <= smp;
          end
        end
        default: ;
      endcase
    end
  end

  a_beat_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(samples.valid) |-> $past(state) == fmsyn_pkg::S_DONE)
    else $error("sample beat raised outside the done step");

  a_last_operator: assert property (@(posedge clk) disable iff (rst)
    (state == fmsyn_pkg::S_OUT && op_car && ch == LastCh) |=> state == fmsyn_pkg::S_DONE)
    else $error("sequencer ran past the last carrier");

  a_off_tick: assert property (@(posedge clk) disable iff (rst)
    (state == fmsyn_pkg::S_IDLE && items.valid && items.command == fmsyn_pkg::CmdTick
     && !enable) |=> (state == fmsyn_pkg::S_DONE && mix == '0))
    else $error("disabled tick did not go straight to the midpoint sample");

endmodule

`default_nettype wire
